// ===== design/i2c_register_access_master_top_macros.svh =====
// ----------------------------------------------------------------------------
// I2C register access master - assertion macros
// Concurrent assertion helpers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH
`define I2C_REGISTER_ACCESS_MASTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked outside reset
`define I2CRAM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("i2c register access master: assertion failed");
// next-cycle implication, checked outside reset
`define I2CRAM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("i2c register access master: assertion failed");
`else
`define I2CRAM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CRAM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/i2cram_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C register access master - package
// Word types, operation codes and configuration defaults.
// ----------------------------------------------------------------------------
package i2cram_pkg;

  localparam int unsigned AddrW  = 7;
  localparam int unsigned TicksW = 4;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 7;

  // operation codes
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_BIT_SETUP  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_BIT_HIGH   = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_START_STOP = 2'd3;

  // configuration reset values
  localparam logic [AddrW-1:0]  DEV_ADDR_RST   = 7'h18;
  localparam logic [TicksW-1:0] BIT_SETUP_RST  = 4'd2;
  localparam logic [TicksW-1:0] BIT_HIGH_RST   = 4'd4;
  localparam logic [TicksW-1:0] START_STOP_RST = 4'd5;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] reg_addr;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_drive;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       nack_seen;
  } out_item_t;

endpackage

// ===== design/i2cram_in_if.sv =====
// ----------------------------------------------------------------------------
// I2C register access master - input channel
// Valid/ready channel carrying one tick word.
// ----------------------------------------------------------------------------
interface i2cram_in_if;
  logic                 valid;
  logic                 ready;
  i2cram_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/i2cram_out_if.sv =====
// ----------------------------------------------------------------------------
// I2C register access master - result channel
// Valid/ready channel carrying one bus-level word.
// ----------------------------------------------------------------------------
interface i2cram_out_if;
  logic                  valid;
  logic                  ready;
  i2cram_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/i2c_register_access_master_top.sv =====
// The result word for a tick is in the output register in the cycle after acceptance.
// Throughput: one tick word per cycle; the sequencer update is a single registered pass.
// A new word is taken only while the output register is empty or being read out,
// so a stalled result holds the input.
// Reset (rst_n low, synchronous): output register empty, sequencer state cleared, configuration
// registers back to address 0x18, setup 2, high 4, start/stop 5 ticks.
// ----------------------------------------------------------------------------
// I2C register access master - top level
// Tick-driven I2C master running single-register write and read transfers.
// ----------------------------------------------------------------------------
`include "i2c_register_access_master_top_macros.svh"

module i2c_register_access_master_top (
  input  logic                                clk,
  input  logic                                rst_n,
  i2cram_in_if.sink                           in_ch,
  i2cram_out_if.source                        out_ch,
  input  logic                                cfg_we,
  input  logic [i2cram_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [i2cram_pkg::CfgDataW-1:0]     cfg_wdata
);
  import i2cram_pkg::*;

  // sequencer phases
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_A    = 4'd1;
  localparam logic [3:0] PH_START_B    = 4'd2;
  localparam logic [3:0] PH_WB_SETUP   = 4'd3;
  localparam logic [3:0] PH_WB_HIGH    = 4'd4;
  localparam logic [3:0] PH_WB_HOLD    = 4'd5;
  localparam logic [3:0] PH_ACK_SETUP  = 4'd6;
  localparam logic [3:0] PH_ACK_HIGH   = 4'd7;
  localparam logic [3:0] PH_RS_PREP    = 4'd8;
  localparam logic [3:0] PH_RB_LOW     = 4'd9;
  localparam logic [3:0] PH_RB_HIGH    = 4'd10;
  localparam logic [3:0] PH_NACK_SETUP = 4'd11;
  localparam logic [3:0] PH_NACK_HIGH  = 4'd12;
  localparam logic [3:0] PH_STOP_PREP  = 4'd13;
  localparam logic [3:0] PH_STOP_A     = 4'd14;
  localparam logic [3:0] PH_STOP_B     = 4'd15;

  // configuration
  logic [AddrW-1:0]  dev_addr_r;
  logic [TicksW-1:0] bit_setup_r, bit_high_r, start_stop_r;

  // sequencer state
  logic [3:0]        phase_r, phase_nxt;
  logic [TicksW-1:0] tick_r, tick_nxt;
  logic [2:0]        bit_idx_r, bit_idx_nxt;
  logic [1:0]        byte_step_r, byte_step_nxt;
  logic              is_read_r, is_read_nxt;
  logic [7:0]        reg_latch_r, reg_latch_nxt;
  logic [7:0]        data_latch_r, data_latch_nxt;
  logic [7:0]        shift_in_r, shift_in_nxt;
  logic              nack_r, nack_nxt;
  logic [7:0]        read_res_r, read_res_nxt;

  // output register
  logic              out_valid_r;
  out_item_t         out_data_r, out_data_nxt;

  logic              fire;
  logic              cmd;
  logic [3:0]        ph_cur;
  logic [TicksW-1:0] tick_cur;
  logic [TicksW-1:0] len_raw;
  logic [TicksW-1:0] len;
  logic              last;
  logic [7:0]        cur_byte;
  logic              tx_bit;
  logic              scl, drive, lvl;

  assign fire = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data = out_data_r;

  always_comb begin
    cmd = (phase_r == PH_IDLE) &&
          (in_ch.data.operation == OP_WRITE || in_ch.data.operation == OP_READ);

    // a command start already shows the first START tick
    ph_cur         = cmd ? PH_START_A : phase_r;
    tick_cur       = cmd ? '0 : tick_r;
    byte_step_nxt  = cmd ? 2'd0 : byte_step_r;
    bit_idx_nxt    = cmd ? 3'd7 : bit_idx_r;
    is_read_nxt    = cmd ? (in_ch.data.operation == OP_READ) : is_read_r;
    reg_latch_nxt  = cmd ? in_ch.data.reg_addr : reg_latch_r;
    data_latch_nxt = cmd ? in_ch.data.write_data : data_latch_r;
    nack_nxt       = cmd ? 1'b0 : nack_r;
    shift_in_nxt   = shift_in_r;
    read_res_nxt   = read_res_r;

    case (byte_step_nxt)
      2'd0:    cur_byte = {dev_addr_r, 1'b0};
      2'd1:    cur_byte = reg_latch_nxt;
      default: cur_byte = is_read_nxt ? {dev_addr_r, 1'b1} : data_latch_nxt;
    endcase
    tx_bit = cur_byte[bit_idx_nxt];

    scl = 1'b1; drive = 1'b1; lvl = 1'b1;
    case (ph_cur)
      PH_START_B, PH_STOP_A: lvl = 1'b0;
      PH_WB_SETUP, PH_WB_HOLD: begin
        scl = 1'b0; lvl = tx_bit;
      end
      PH_WB_HIGH: lvl = tx_bit;
      PH_ACK_SETUP, PH_RB_LOW: begin
        scl = 1'b0; drive = 1'b0; lvl = 1'b0;
      end
      PH_ACK_HIGH, PH_RB_HIGH: begin
        drive = 1'b0; lvl = 1'b0;
      end
      PH_RS_PREP, PH_NACK_SETUP: scl = 1'b0;
      PH_STOP_PREP: begin
        scl = 1'b0; lvl = 1'b0;
      end
      default: ;
    endcase

    case (ph_cur)
      PH_START_A, PH_START_B, PH_STOP_A, PH_STOP_B: len_raw = start_stop_r;
      PH_WB_HIGH, PH_ACK_HIGH, PH_RB_HIGH, PH_NACK_HIGH: len_raw = bit_high_r;
      default: len_raw = bit_setup_r;
    endcase
    // a zero tick count acts as one
    len = (len_raw == '0) ? TicksW'(1) : len_raw;
    last = ({1'b0, tick_cur} + 1'b1) >= {1'b0, len};

    phase_nxt = ph_cur;
    tick_nxt  = tick_cur;
    out_data_nxt.done_res = 1'b0;

    if (ph_cur != PH_IDLE) begin
      if (last && ph_cur == PH_ACK_HIGH && in_ch.data.sda_in) nack_nxt = 1'b1;
      if (last && ph_cur == PH_RB_HIGH) shift_in_nxt = {shift_in_r[6:0], in_ch.data.sda_in};
      if (!last) begin
        tick_nxt = tick_cur + 1'b1;
      end else begin
        tick_nxt = '0;
        unique case (ph_cur)
          PH_START_A: phase_nxt = PH_START_B;
          PH_START_B: begin
            bit_idx_nxt = 3'd7; phase_nxt = PH_WB_SETUP;
          end
          PH_WB_SETUP: phase_nxt = PH_WB_HIGH;
          PH_WB_HIGH:  phase_nxt = PH_WB_HOLD;
          PH_WB_HOLD: begin
            if (bit_idx_nxt == 3'd0) begin
              phase_nxt = PH_ACK_SETUP;
            end else begin
              bit_idx_nxt = bit_idx_nxt - 1'b1; phase_nxt = PH_WB_SETUP;
            end
          end
          PH_ACK_SETUP: phase_nxt = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            if (byte_step_nxt == 2'd0) begin
              byte_step_nxt = 2'd1; bit_idx_nxt = 3'd7; phase_nxt = PH_WB_SETUP;
            end else if (byte_step_nxt == 2'd1) begin
              byte_step_nxt = 2'd2;
              if (is_read_nxt) begin
                phase_nxt = PH_RS_PREP;
              end else begin
                bit_idx_nxt = 3'd7; phase_nxt = PH_WB_SETUP;
              end
            end else if (is_read_nxt) begin
              shift_in_nxt = '0; bit_idx_nxt = 3'd7; phase_nxt = PH_RB_LOW;
            end else begin
              phase_nxt = PH_STOP_PREP;
            end
          end
          PH_RS_PREP: phase_nxt = PH_START_A;
          PH_RB_LOW:  phase_nxt = PH_RB_HIGH;
          PH_RB_HIGH: begin
            if (bit_idx_nxt == 3'd0) begin
              phase_nxt = PH_NACK_SETUP;
            end else begin
              bit_idx_nxt = bit_idx_nxt - 1'b1; phase_nxt = PH_RB_LOW;
            end
          end
          PH_NACK_SETUP: phase_nxt = PH_NACK_HIGH;
          PH_NACK_HIGH: begin
            read_res_nxt = shift_in_r; phase_nxt = PH_STOP_PREP;
          end
          PH_STOP_PREP: phase_nxt = PH_STOP_A;
          PH_STOP_A:    phase_nxt = PH_STOP_B;
          PH_STOP_B: begin
            phase_nxt = PH_IDLE; out_data_nxt.done_res = 1'b1;
          end
          default: phase_nxt = PH_IDLE;
        endcase
      end
    end

    out_data_nxt.scl_out   = scl;
    out_data_nxt.sda_drive = drive;
    out_data_nxt.sda_out   = lvl;
    out_data_nxt.busy_res  = (phase_nxt != PH_IDLE);
    out_data_nxt.read_data = read_res_nxt;
    out_data_nxt.nack_seen = nack_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r   <= DEV_ADDR_RST;
      bit_setup_r  <= BIT_SETUP_RST;
      bit_high_r   <= BIT_HIGH_RST;
      start_stop_r <= START_STOP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEV_ADDR:   dev_addr_r   <= cfg_wdata[AddrW-1:0];
        CFG_BIT_SETUP:  bit_setup_r  <= cfg_wdata[TicksW-1:0];
        CFG_BIT_HIGH:   bit_high_r   <= cfg_wdata[TicksW-1:0];
        CFG_START_STOP: start_stop_r <= cfg_wdata[TicksW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state: advance on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      tick_r       <= '0;
      bit_idx_r    <= 3'd7;
      byte_step_r  <= 2'd0;
      is_read_r    <= 1'b0;
      reg_latch_r  <= '0;
      data_latch_r <= '0;
      shift_in_r   <= '0;
      nack_r       <= 1'b0;
      read_res_r   <= '0;
    end else if (fire) begin
      phase_r      <= phase_nxt;
      tick_r       <= tick_nxt;
      bit_idx_r    <= bit_idx_nxt;
      byte_step_r  <= byte_step_nxt;
      is_read_r    <= is_read_nxt;
      reg_latch_r  <= reg_latch_nxt;
      data_latch_r <= data_latch_nxt;
      shift_in_r   <= shift_in_nxt;
      nack_r       <= nack_nxt;
      read_res_r   <= read_res_nxt;
    end
  end

  // output register: hold until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  `I2CRAM_ASSERT_IMP(a_idle_tick_clear, clk, rst_n, phase_r == PH_IDLE, tick_r == '0)
  `I2CRAM_ASSERT_IMP(a_done_not_busy, clk, rst_n, out_valid_r && out_data_r.done_res, !out_data_r.busy_res)
  `I2CRAM_ASSERT_IMP(a_released_low, clk, rst_n, out_valid_r && !out_data_r.sda_drive, !out_data_r.sda_out)
  `I2CRAM_ASSERT_NXT(a_fire_gives_word, clk, rst_n, fire, out_valid_r)

endmodule
